// ----- design/sfla_pkg.sv -----
package sfla_pkg;

  localparam int STEP_BYTES  = 16;
  localparam int MAX_BYTES   = 256;
  localparam int BATCH_BYTES = 4096;
  localparam int ARENA_BYTES = 65536;

  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = 16;
  localparam int STEP_SHIFT = $clog2(STEP_BYTES);

  localparam int NCLASS  = (MAX_BYTES + STEP_BYTES - 1) / STEP_BYTES + 1;
  localparam int CLS_W   = $clog2(NCLASS);
  localparam int CSTEP_W = $clog2((NCLASS - 1) * STEP_BYTES + 1);

  localparam int LINK_IDX_W = ADDR_W - STEP_SHIFT;
  localparam int NLINKS     = 1 << LINK_IDX_W;
  localparam int LINK_W     = ADDR_W + 1;

  localparam int NBATCH = ARENA_BYTES / BATCH_BYTES;
  localparam int BU_W   = $clog2(NBATCH + 1);
  localparam int OFF_W  = $clog2(BATCH_BYTES) + 2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERSIZE = 2'd1;
  localparam logic [1:0] ST_NOMEM    = 2'd2;
  localparam logic [1:0] ST_ZERO     = 2'd3;

  // What the control has to do with a decoded request.
  localparam logic [1:0] KIND_RESULT = 2'd0;
  localparam logic [1:0] KIND_PUSH   = 2'd1;
  localparam logic [1:0] KIND_ALLOC  = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [CLS_W-1:0] cls;
  } req_info_t;

endpackage

// ----- design/sfla_req_decode.sv -----
module sfla_req_decode
  import sfla_pkg::*;
(
  input  logic              req_type,
  input  logic [SIZE_W-1:0] size_bytes,
  input  logic [ADDR_W-1:0] block_addr,
  input  logic              addr_is_null,
  output req_info_t         info
);

  logic [SIZE_W:0] size_round;
  logic            size_zero;
  logic            size_over;
  logic            in_arena;

  assign size_round = {1'b0, size_bytes} + (SIZE_W + 1)'(STEP_BYTES - 1);
  assign size_zero  = (size_bytes == '0);
  assign size_over  = (32'(size_bytes) > MAX_BYTES);
  assign in_arena   = (32'(block_addr) < ARENA_BYTES);

  // The class is only meaningful once the size is known to be in range.
  always_comb begin
    info.cls    = size_round[STEP_SHIFT +: CLS_W];
    info.status = ST_OK;
    info.kind   = KIND_RESULT;
    if (req_type == REQ_FREE) begin
      if (addr_is_null) begin
        info.status = ST_OK;
      end else if (size_zero) begin
        info.status = ST_ZERO;
      end else if (size_over) begin
        info.status = ST_OVERSIZE;
      end else if (in_arena) begin
        info.kind = KIND_PUSH;
      end
    end else begin
      if (size_zero) begin
        info.status = ST_ZERO;
      end else if (size_over) begin
        info.status = ST_OVERSIZE;
      end else begin
        info.kind = KIND_ALLOC;
      end
    end
  end

endmodule

// ----- design/size_class_free_list_allocator_unit.sv -----
// Channel   Direction  Handshake             Beat contents
// request   in         in_valid / in_stall   req_type, size_bytes, block_addr, addr_is_null
// result    out        out_valid / out_stall granted_addr, status
//
// A free, a flagged request or an alloc that finds no memory is settled in
// S_EXEC, an alloc from a non-empty class list adds S_POP for the link RAM
// read, and a refilling alloc walks the batch in S_CARVE, one link per cycle.
// Reset clears the list valid bits and the batch count; the link RAM is not
// cleared, as no link is read before it is written. A stalled result lets one
// more request in, whose result then waits with the input stalled.
module size_class_free_list_allocator_unit
  import sfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [SIZE_W-1:0] size_bytes,
  input  logic [ADDR_W-1:0] block_addr,
  input  logic              addr_is_null,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] granted_addr,
  output logic [1:0]        status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_CARVE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state;

  // The request is held here for the whole time it is being worked on.
  logic              rq_type;
  logic [SIZE_W-1:0] rq_size;
  logic [ADDR_W-1:0] rq_addr;
  logic              rq_null;
  req_info_t         dec;

  // Class list heads: a valid bit per class in flops, the address beside it.
  logic [NCLASS-1:0] head_valid;
  logic [ADDR_W-1:0] head_addr [NCLASS];
  logic [BU_W-1:0]   batches_used;

  // Link RAM, one entry per STEP_BYTES slot of the arena, valid bit on top.
  logic [LINK_W-1:0]     link_mem [NLINKS];
  logic                  mem_we;
  logic [LINK_IDX_W-1:0] mem_waddr;
  logic [LINK_W-1:0]     mem_wdata;
  logic                  mem_re;
  logic [LINK_IDX_W-1:0] mem_raddr;
  logic [LINK_W-1:0]     mem_rdata;

  // Refill walk state.
  logic [OFF_W-1:0]   off;
  logic [LINK_W-1:0]  prev;
  logic [CSTEP_W-1:0] cls_step;
  logic [OFF_W-1:0]   off_plus;
  logic [ADDR_W-1:0]  batch_base;
  logic [ADDR_W-1:0]  carve_addr;
  logic               carve_last;
  logic               no_batch;

  logic              cur_valid;
  logic [ADDR_W-1:0] cur_addr;

  logic [ADDR_W-1:0] res_addr;
  logic [1:0]        res_status;

  logic              fin;
  logic [ADDR_W-1:0] fin_addr;
  logic [1:0]        fin_status;
  logic              out_free;

  sfla_req_decode u_decode (
    .req_type     (rq_type),
    .size_bytes   (rq_size),
    .block_addr   (rq_addr),
    .addr_is_null (rq_null),
    .info         (dec)
  );

  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign cur_valid = head_valid[dec.cls];
  assign cur_addr  = head_addr[dec.cls];

  // Blocks of a class are class * STEP_BYTES bytes. A batch holds the blocks
  // whose end still lies inside it; the walk stops at the highest of them.
  assign cls_step   = CSTEP_W'(32'(dec.cls) * STEP_BYTES);
  assign off_plus   = off + OFF_W'(cls_step);
  assign carve_last = (32'(off_plus) + 32'(cls_step)) > BATCH_BYTES;
  assign batch_base = ADDR_W'(32'(batches_used) * BATCH_BYTES);
  assign carve_addr = batch_base + ADDR_W'(off);
  assign no_batch   = (32'(cls_step) > BATCH_BYTES) || (32'(batches_used) >= NBATCH);

  // A free pushes onto its list: the old head becomes the link of the freed
  // block. A refill links each carved block to the one below it.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = carve_addr[STEP_SHIFT +: LINK_IDX_W];
    mem_wdata = prev;
    mem_re    = 1'b0;
    mem_raddr = cur_addr[STEP_SHIFT +: LINK_IDX_W];
    if ((state == S_EXEC) && (dec.kind == KIND_PUSH)) begin
      mem_we    = 1'b1;
      mem_waddr = rq_addr[STEP_SHIFT +: LINK_IDX_W];
      mem_wdata = {cur_valid, cur_addr};
    end else if (state == S_CARVE) begin
      mem_we = 1'b1;
    end
    if ((state == S_EXEC) && (dec.kind == KIND_ALLOC) && cur_valid) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= link_mem[mem_raddr];
    end
  end

  // The cycle in which a request's result is settled.
  always_comb begin
    fin        = 1'b0;
    fin_addr   = '0;
    fin_status = ST_OK;
    case (state)
      S_EXEC: begin
        case (dec.kind)
          KIND_RESULT: begin
            fin        = 1'b1;
            fin_status = dec.status;
          end
          KIND_PUSH: begin
            fin = 1'b1;
          end
          KIND_ALLOC: begin
            if (!cur_valid && no_batch) begin
              fin        = 1'b1;
              fin_status = ST_NOMEM;
            end
          end
          default: begin
            fin = 1'b0;
          end
        endcase
      end
      S_POP: begin
        fin      = 1'b1;
        fin_addr = res_addr;
      end
      S_CARVE: begin
        if (carve_last) begin
          fin      = 1'b1;
          fin_addr = carve_addr;
        end
      end
      S_RESP: begin
        fin        = 1'b1;
        fin_addr   = res_addr;
        fin_status = res_status;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      head_valid   <= '0;
      batches_used <= '0;
    end else begin
      // The output register empties when its beat is taken, unless the next
      // result moves in at the same edge.
      if (out_valid && !out_stall && !fin) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rq_type <= req_type;
            rq_size <= size_bytes;
            rq_addr <= block_addr;
            rq_null <= addr_is_null;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (dec.kind == KIND_PUSH) begin
            head_valid[dec.cls] <= 1'b1;
            head_addr[dec.cls]  <= rq_addr;
          end else if (dec.kind == KIND_ALLOC) begin
            if (cur_valid) begin
              res_addr <= cur_addr;
              state    <= S_POP;
            end else if (!no_batch) begin
              off   <= '0;
              prev  <= '0;
              state <= S_CARVE;
            end
          end
        end
        S_POP: begin
          head_valid[dec.cls] <= mem_rdata[ADDR_W];
          head_addr[dec.cls]  <= mem_rdata[ADDR_W-1:0];
        end
        S_CARVE: begin
          if (!carve_last) begin
            prev <= {1'b1, carve_addr};
            off  <= off_plus;
          end else begin
            // The highest block is handed out at once, so the list starts
            // at the block below it, which is the link just written.
            head_valid[dec.cls] <= prev[ADDR_W];
            head_addr[dec.cls]  <= prev[ADDR_W-1:0];
            batches_used        <= batches_used + BU_W'(1);
          end
        end
        S_RESP: begin
          // The held result leaves through the output register below.
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (fin) begin
        if (out_free) begin
          out_valid    <= 1'b1;
          granted_addr <= fin_addr;
          status       <= fin_status;
          state        <= S_IDLE;
        end else begin
          res_addr   <= fin_addr;
          res_status <= fin_status;
          state      <= S_RESP;
        end
      end
    end
  end

endmodule

// ----- design/sfla_checker.sv -----
module sfla_checker
  import sfla_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              req_type,
  input logic [SIZE_W-1:0] size_bytes,
  input logic [ADDR_W-1:0] block_addr,
  input logic              addr_is_null,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ADDR_W-1:0] granted_addr,
  input logic [1:0]        status
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(granted_addr) && $stable(status))
    else $error("result beat changed while stalled");

  // One request at a time: an accepted beat closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in progress");

  // Only a successful allocation carries an address.
  a_addr_on_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> granted_addr == '0)
    else $error("address given with a failing status");

  // Reset leaves no result behind.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat present after reset");

endmodule

bind size_class_free_list_allocator_unit sfla_checker u_sfla_checker (.*);

// ----- tb/size_class_free_list_allocator_unit_test.sv -----
`timescale 1ns / 100ps

module size_class_free_list_allocator_unit_test;
  import sfla_pkg::*;

  // The random part counts only requests that the allocator acts upon.
  // A null free is ignored by the block, so it does not add to the count.
  localparam int RANDOM_ITEMS = 1150;
  // A refill of class one writes 256 links, the slowest request of all.
  // The limit covers many times the slowest run.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int NUM_DIRECTED = 23;

  // Kinds of malformed or unusual requests mixed into the random part.
  typedef enum int {
    NOISE_ZERO_ALLOC,
    NOISE_ZERO_FREE,
    NOISE_BIG_ALLOC,
    NOISE_BIG_FREE,
    NOISE_NULL_FREE,
    NOISE_WILD_FREE,
    NOISE_DOUBLE_FREE,
    NOISE_KINDS
  } noise_kind_t;

  // One result beat as the allocator should produce it.
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } grant_t;

  // A block that the allocator handed out and that has not been freed yet.
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_block_t;

  // One row of the directed table. Where known is set, the expected beat
  // is typed in the row; otherwise it comes from the predictor.
  typedef struct {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              nul;
    bit                known;
    logic [ADDR_W-1:0] exp_addr;
    logic [1:0]        exp_status;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] block_addr;
  logic              addr_is_null;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] granted_addr;
  logic [1:0]        status;

  // Predictor state: a head per size class and a link per 16-byte slot of
  // the arena. Bit ADDR_W of a head or link marks it as valid.
  logic [LINK_W-1:0] list_head [NCLASS];
  logic [LINK_W-1:0] link_ram [NLINKS];
  int                batch_count;

  grant_t      pending_grants[$];
  live_block_t live_blocks[$];
  dir_row_t    directed_rows [NUM_DIRECTED];
  grant_t      oldest_grant;

  int sender_idle_pct;
  int recv_idle_pct;
  int error_count;
  int cycle_count;
  int accepted_count;
  int status_tally [4];

  size_class_free_list_allocator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .size_bytes   (size_bytes),
    .block_addr   (block_addr),
    .addr_is_null (addr_is_null),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .granted_addr (granted_addr),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Carve the next batch of the arena into blocks of the given class. The
  // lowest block ends its list, so the highest block becomes the head.
  function automatic bit carve_batch(int cls);
    int                step;
    int                base;
    int                count;
    logic [LINK_W-1:0] prev;
    logic [ADDR_W-1:0] blk;
    step = cls * STEP_BYTES;
    base = batch_count * BATCH_BYTES;
    if (step == 0 || step > BATCH_BYTES || base + BATCH_BYTES > ARENA_BYTES) begin
      return 1'b0;
    end
    count = BATCH_BYTES / step;
    prev  = '0;
    for (int i = 0; i < count; i++) begin
      blk = ADDR_W'(base + i * step);
      link_ram[blk[ADDR_W-1:STEP_SHIFT]] = prev;
      prev = {1'b1, blk};
    end
    list_head[cls] = prev;
    batch_count++;
    return 1'b1;
  endfunction

  // Work out the result beat of one request and update the predictor state.
  function automatic grant_t predict_grant(logic op, logic [SIZE_W-1:0] size,
                                           logic [ADDR_W-1:0] addr, logic nul);
    grant_t r;
    int     cls;
    r.addr   = '0;
    r.status = ST_OK;
    cls = (int'(size) + STEP_BYTES - 1) / STEP_BYTES;
    if (op == REQ_FREE) begin
      // A null free is ignored ahead of every size check.
      if (!nul) begin
        if (size == 0) begin
          r.status = ST_ZERO;
        end else if (size > MAX_BYTES) begin
          r.status = ST_OVERSIZE;
        end else if (int'(addr) < ARENA_BYTES) begin
          // The address is pushed as given: unaligned, doubled or of the
          // wrong class, nothing is checked.
          link_ram[addr[ADDR_W-1:STEP_SHIFT]] = list_head[cls];
          list_head[cls] = {1'b1, addr};
        end
      end
    end else begin
      if (size == 0) begin
        r.status = ST_ZERO;
      end else if (size > MAX_BYTES) begin
        r.status = ST_OVERSIZE;
      end else if (cls >= NCLASS) begin
        r.status = ST_NOMEM;
      end else if (!list_head[cls][ADDR_W] && !carve_batch(cls)) begin
        r.status = ST_NOMEM;
      end else begin
        r.addr = list_head[cls][ADDR_W-1:0];
        list_head[cls] = link_ram[r.addr[ADDR_W-1:STEP_SHIFT]];
      end
    end
    return r;
  endfunction

  // Half of the sizes are uniform, the other half sit on a class edge:
  // exactly a multiple of the step, or one byte past it.
  function automatic logic [SIZE_W-1:0] pick_size();
    int k;
    if ($urandom_range(1) == 0) begin
      return SIZE_W'($urandom_range(MAX_BYTES, 1));
    end
    k = $urandom_range(MAX_BYTES / STEP_BYTES, 1);
    if ($urandom_range(1) == 0) begin
      return SIZE_W'(k * STEP_BYTES);
    end
    return SIZE_W'((k - 1) * STEP_BYTES + 1);
  endfunction

  // Drive one request beat at the falling edge, hold it until the block
  // takes it, then record the expected result beat.
  task automatic send_request(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr,
                              logic nul, bit known, logic [ADDR_W-1:0] exp_addr,
                              logic [1:0] exp_status);
    grant_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= op;
    size_bytes   <= size;
    block_addr   <= addr;
    addr_is_null <= nul;
    do @(posedge clk); while (in_stall);
    predicted = predict_grant(op, size, addr, nul);
    if (op == REQ_ALLOC && predicted.status == ST_OK) begin
      live_blocks.push_back('{predicted.addr, size});
    end
    if (known) begin
      predicted.addr   = exp_addr;
      predicted.status = exp_status;
    end
    pending_grants.push_back(predicted);
    accepted_count++;
  endtask

  // Random traffic. Most of it is well-formed: allocations of legal sizes,
  // and frees of blocks that were actually granted, with a size from the
  // same class. About a fifth is noise that hits the flagged and ignored
  // paths, or frees wild, unaligned or already freed addresses.
  task automatic run_random(int n);
    int                done;
    int                choice;
    int                pick;
    int                cls;
    live_block_t       blk;
    logic [ADDR_W-1:0] addr;
    done = 0;
    while (done < n) begin
      choice = $urandom_range(99);
      addr   = ADDR_W'($urandom);
      if (choice < 55 || (choice < 80 && live_blocks.size() == 0)) begin
        send_request(REQ_ALLOC, pick_size(), addr, 1'($urandom_range(1)), 1'b0, '0, ST_OK);
      end else if (choice < 80) begin
        pick = $urandom_range(live_blocks.size() - 1);
        blk  = live_blocks[pick];
        live_blocks.delete(pick);
        cls  = (int'(blk.size) + STEP_BYTES - 1) / STEP_BYTES;
        send_request(REQ_FREE, SIZE_W'((cls - 1) * STEP_BYTES + $urandom_range(STEP_BYTES, 1)),
                     blk.addr, 1'b0, 1'b0, '0, ST_OK);
      end else begin
        case ($urandom_range(NOISE_KINDS - 1))
          NOISE_ZERO_ALLOC: begin
            send_request(REQ_ALLOC, '0, addr, 1'($urandom_range(1)), 1'b0, '0, ST_OK);
          end
          NOISE_ZERO_FREE: begin
            send_request(REQ_FREE, '0, addr, 1'b0, 1'b0, '0, ST_OK);
          end
          NOISE_BIG_ALLOC: begin
            send_request(REQ_ALLOC, SIZE_W'($urandom_range(65535, MAX_BYTES + 1)), addr,
                         1'($urandom_range(1)), 1'b0, '0, ST_OK);
          end
          NOISE_BIG_FREE: begin
            send_request(REQ_FREE, SIZE_W'($urandom_range(65535, MAX_BYTES + 1)), addr,
                         1'b0, 1'b0, '0, ST_OK);
          end
          NOISE_NULL_FREE: begin
            // Ignored by the block, so it does not advance the count.
            send_request(REQ_FREE, SIZE_W'($urandom), addr, 1'b1, 1'b0, '0, ST_OK);
            done--;
          end
          NOISE_WILD_FREE: begin
            send_request(REQ_FREE, pick_size(), addr, 1'b0, 1'b0, '0, ST_OK);
          end
          default: begin
            // Free a live block again without retiring it, under any class.
            if (live_blocks.size() != 0) begin
              addr = live_blocks[$urandom_range(live_blocks.size() - 1)].addr;
            end
            send_request(REQ_FREE, pick_size(), addr, 1'b0, 1'b0, '0, ST_OK);
          end
        endcase
      end
      done++;
    end
  endtask

  // The result side stalls at random, changing only at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Each result beat taken at a rising edge is matched with the oldest
  // expected beat, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $error("result beat with nothing expected: granted_addr %0d, status %0d",
               granted_addr, status);
        error_count++;
      end else begin
        oldest_grant = pending_grants.pop_front();
        if (granted_addr !== oldest_grant.addr) begin
          $error("granted_addr: expected %0d, got %0d", oldest_grant.addr, granted_addr);
          error_count++;
        end
        if (status !== oldest_grant.status) begin
          $error("status: expected %0d, got %0d", oldest_grant.status, status);
          error_count++;
        end
        status_tally[oldest_grant.status]++;
      end
    end
  end

  // Hard stop in case the block hangs or drops a beat.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_ALLOC;
    size_bytes   = '0;
    block_addr   = '0;
    addr_is_null = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    accepted_count = 0;
    batch_count  = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (list_head[i]) list_head[i] = '0;
    foreach (link_ram[i]) link_ram[i] = '0;

    // Directed part. The first allocation after reset carves batch zero into
    // 16-byte blocks and gets the highest one; a 256-byte class takes the
    // next batch. An unaligned free at the top of the arena comes back as is,
    // a double free hands the same block out twice, and a null free wins over
    // every size check.
    directed_rows = '{
      '{REQ_ALLOC, 16'd16,    16'd0,     1'b0, 1'b1, 16'd4080,  ST_OK},
      '{REQ_ALLOC, 16'd0,     16'd0,     1'b0, 1'b1, 16'd0,     ST_ZERO},
      '{REQ_FREE,  16'd0,     16'h0100,  1'b0, 1'b1, 16'd0,     ST_ZERO},
      '{REQ_ALLOC, 16'd257,   16'd0,     1'b0, 1'b1, 16'd0,     ST_OVERSIZE},
      '{REQ_ALLOC, 16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 16'd0,     ST_OVERSIZE},
      '{REQ_FREE,  16'hFFFF,  16'h1234,  1'b0, 1'b1, 16'd0,     ST_OVERSIZE},
      '{REQ_FREE,  16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 16'd0,     ST_OK},
      '{REQ_ALLOC, 16'd256,   16'd0,     1'b0, 1'b1, 16'd7936,  ST_OK},
      '{REQ_ALLOC, 16'd1,     16'd0,     1'b0, 1'b1, 16'd4064,  ST_OK},
      '{REQ_FREE,  16'd16,    16'd4080,  1'b0, 1'b1, 16'd0,     ST_OK},
      '{REQ_ALLOC, 16'd9,     16'd0,     1'b0, 1'b1, 16'd4080,  ST_OK},
      '{REQ_FREE,  16'd17,    16'hFFFF,  1'b0, 1'b1, 16'd0,     ST_OK},
      '{REQ_ALLOC, 16'd32,    16'd0,     1'b0, 1'b1, 16'hFFFF,  ST_OK},
      '{REQ_ALLOC, 16'd32,    16'd0,     1'b0, 1'b0, 16'd0,     ST_OK},
      '{REQ_FREE,  16'd256,   16'd7936,  1'b0, 1'b1, 16'd0,     ST_OK},
      '{REQ_FREE,  16'd256,   16'd7936,  1'b0, 1'b1, 16'd0,     ST_OK},
      '{REQ_ALLOC, 16'd241,   16'd0,     1'b0, 1'b0, 16'd0,     ST_OK},
      '{REQ_ALLOC, 16'd256,   16'd0,     1'b0, 1'b0, 16'd0,     ST_OK},
      '{REQ_FREE,  16'd1,     16'd0,     1'b0, 1'b1, 16'd0,     ST_OK},
      '{REQ_ALLOC, 16'd1,     16'd0,     1'b0, 1'b0, 16'd0,     ST_OK},
      '{REQ_FREE,  16'd128,   16'h8000,  1'b0, 1'b1, 16'd0,     ST_OK},
      '{REQ_ALLOC, 16'd113,   16'd0,     1'b0, 1'b0, 16'd0,     ST_OK},
      '{REQ_FREE,  16'd0,     16'd0,     1'b1, 1'b1, 16'd0,     ST_OK}
    };

    // First phase: the sender idles a little, the receiver a lot.
    sender_idle_pct = 16;
    recv_idle_pct   = 45;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].size, directed_rows[i].addr,
                   directed_rows[i].nul, directed_rows[i].known,
                   directed_rows[i].exp_addr, directed_rows[i].exp_status);
    end
    run_random(RANDOM_ITEMS / 3);

    // Second phase swaps the idle rates; the third runs at full speed.
    sender_idle_pct = 45;
    recv_idle_pct   = 16;
    run_random(RANDOM_ITEMS / 3);
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every expected beat, then a little longer for strays.
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d directed), %0d of %0d arena batches carved.",
             accepted_count, NUM_DIRECTED, batch_count, ARENA_BYTES / BATCH_BYTES);
    $display("Results: %0d ok, %0d oversize, %0d out of memory, %0d zero size.",
             status_tally[ST_OK], status_tally[ST_OVERSIZE], status_tally[ST_NOMEM],
             status_tally[ST_ZERO]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
